### src/assert_macros.svh
// Assertion macros used by the checker module of the prefix-need block.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/stpn_pkg.sv
// Package for the segment-tree prefix-need block: field widths, stream
// packing offsets, summary type, codes and the sequencer state type. No dependencies.
`default_nettype none

package stpn_pkg;

  // Default sizing of the trees
  localparam int ROWS_DEF    = 1024;
  localparam int COLUMNS_DEF = 16;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int COL_W    = 4;
  localparam int ROW_W    = 10;
  localparam int LEAF_W   = 62;
  localparam int COST_W   = 63;
  localparam int DEPTH_W  = 31;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  // Input stream packing (tdata, lowest bit first)
  localparam int IN_COL_LSB   = 0;
  localparam int IN_ROW_LSB   = IN_COL_LSB + COL_W;
  localparam int IN_LOW_LSB   = IN_ROW_LSB + ROW_W;
  localparam int IN_COST_LSB  = IN_LOW_LSB + ROW_W;
  localparam int IN_NEED_LSB  = IN_COST_LSB + LEAF_W;
  localparam int IN_DEPTH_LSB = IN_NEED_LSB + LEAF_W;
  localparam int IN_USED_W    = IN_DEPTH_LSB + DEPTH_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;
  localparam int IN_USER_W    = KIND_W;

  // Output stream packing
  localparam int OUT_DATA_W = 2 * COST_W + DEPTH_W + COUNT_W;
  localparam int OUT_USER_W = STATUS_W;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OCCUPIED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Node summary; count zero means empty
  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [COST_W-1:0]  need;
    logic [DEPTH_W-1:0] depth;
    logic [COUNT_W-1:0] count;
  } summ_t;

  localparam int SUMM_W = $bits(summ_t);

  // Join unit result
  typedef struct packed {
    summ_t res;
    logic  sat;
  } join_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_INS_RD,
    S_INS_TEST,
    S_INS_UP,
    S_Q_L,
    S_Q_LJ,
    S_Q_H,
    S_Q_HJ,
    S_Q_FIN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### src/segment_tree_prefix_need_summary.sv
// Insert: one sibling read per tree level; each parent is forwarded, not read back.
// Query: walks up the tree one level at a time; bound by the single RAM read port.
// Clear: writes zero to all 2^(CW+NW) RAM entries, one RAM entry per cycle.
// One transaction in flight; in_tready is high only while idle.
// rst_n (sync, active low) starts the same clearing pass; no input is taken until it ends.
`default_nettype none

module segment_tree_prefix_need_summary #(
  parameter int ROWS    = stpn_pkg::ROWS_DEF,
  parameter int COLUMNS = stpn_pkg::COLUMNS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // column, row, low_row, leaf_cost, leaf_need, leaf_depth, zero pad
  input  wire logic [stpn_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind
  input  wire logic [stpn_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // sum_cost, max_need, max_depth, row_count
  output logic      [stpn_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status
  output logic      [stpn_pkg::OUT_USER_W-1:0]  out_tuser
);

  import stpn_pkg::*;

  localparam int NW    = $clog2(ROWS) + 1;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int AW    = CW + NW;
  localparam int DEPTH = 2 ** AW;
  localparam int LW    = NW + 1;

  // Sequencer state and working registers
  state_t                state_r, state_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [NW-1:0]         k_r, k_nxt;
  logic [LW-1:0]         l_r, l_nxt;
  logic [LW-1:0]         h_r, h_nxt;
  summ_t                 leaf_r, leaf_nxt;
  summ_t                 cur_r, cur_nxt;
  summ_t                 hi_r, hi_nxt;
  summ_t                 res_r, res_nxt;
  logic                  sat_r, sat_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [AW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic                  clr_reply_r, clr_reply_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_USER_W-1:0] out_tuser_r, out_tuser_nxt;

  // Input field decode
  logic [KIND_W-1:0]  in_kind;
  logic [COL_W-1:0]   in_col;
  logic [ROW_W-1:0]   in_row;
  logic [ROW_W-1:0]   in_low;
  logic [LEAF_W-1:0]  in_cost;
  logic [LEAF_W-1:0]  in_need;
  logic [DEPTH_W-1:0] in_depth;
  logic               in_fire;
  logic               col_ok;
  logic               row_ok;
  logic               range_ok;
  logic [31:0]        hi_clamp;
  logic               out_load;

  assign in_kind  = in_tuser[KIND_W-1:0];
  assign in_col   = in_tdata[IN_COL_LSB +: COL_W];
  assign in_row   = in_tdata[IN_ROW_LSB +: ROW_W];
  assign in_low   = in_tdata[IN_LOW_LSB +: ROW_W];
  assign in_cost  = in_tdata[IN_COST_LSB +: LEAF_W];
  assign in_need  = in_tdata[IN_NEED_LSB +: LEAF_W];
  assign in_depth = in_tdata[IN_DEPTH_LSB +: DEPTH_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign col_ok    = 32'(in_col) < 32'(COLUMNS);
  assign row_ok    = 32'(in_row) < 32'(ROWS);
  assign hi_clamp  = row_ok ? 32'(in_row) : 32'(ROWS - 1);
  assign range_ok  = 32'(in_low) <= hi_clamp;
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // Memory and join unit
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [SUMM_W-1:0] ram_wdata, ram_rdata;
  summ_t             rd_summ;
  summ_t             join_a, join_b;
  join_out_t         join_o;
  logic [LW-1:0]     h_dec;
  logic [NW-1:0]     k_up;

  assign rd_summ = summ_t'(ram_rdata);
  assign h_dec   = h_r - 1'b1;
  assign k_up    = k_r >> 1;

  stpn_ram #(
    .WIDTH (SUMM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stpn_join u_join (
    .first  (join_a),
    .second (join_b),
    .result (join_o)
  );

  // Steer the join operands
  always_comb begin
    join_a = cur_r;
    join_b = rd_summ;
    case (state_r)
      S_INS_UP: begin
        if (k_r[0]) begin
          join_a = cur_r;
          join_b = rd_summ;
        end else begin
          join_a = rd_summ;
          join_b = cur_r;
        end
      end
      S_Q_LJ: begin
        join_a = rd_summ;
        join_b = cur_r;
      end
      S_Q_HJ: begin
        join_a = hi_r;
        join_b = rd_summ;
      end
      S_Q_FIN: begin
        join_a = hi_r;
        join_b = cur_r;
      end
      default: begin
        join_a = cur_r;
        join_b = rd_summ;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (&clr_cnt_r) begin
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_INSERT: state_nxt = (col_ok && row_ok) ? S_INS_RD : S_DONE;
            KIND_QUERY:  state_nxt = (col_ok && range_ok) ? S_Q_L : S_DONE;
            KIND_CLEAR:  state_nxt = S_CLR;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_RD:   state_nxt = S_INS_TEST;
      S_INS_TEST: state_nxt = (rd_summ.count != '0) ? S_DONE : S_INS_UP;
      S_INS_UP: begin
        if (k_up == NW'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_Q_L: begin
        if (l_r < h_r) begin
          state_nxt = l_r[0] ? S_Q_LJ : S_Q_H;
        end else begin
          state_nxt = S_Q_FIN;
        end
      end
      S_Q_LJ:  state_nxt = S_Q_H;
      S_Q_H:   state_nxt = h_r[0] ? S_Q_HJ : S_Q_L;
      S_Q_HJ:  state_nxt = S_Q_L;
      S_Q_FIN: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    col_nxt       = col_r;
    k_nxt         = k_r;
    l_nxt         = l_r;
    h_nxt         = h_r;
    leaf_nxt      = leaf_r;
    cur_nxt       = cur_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    sat_nxt       = sat_r;
    status_nxt    = status_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_reply_nxt = clr_reply_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    case (state_r)
      S_CLR: begin
        // Sweep one entry per cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      S_IDLE: begin
        // Latch the transaction; default to an all-zero ok reply
        if (in_fire) begin
          col_nxt        = CW'(in_col);
          k_nxt          = NW'(ROWS) + NW'(in_row);
          l_nxt          = LW'(in_low) + LW'(ROWS);
          h_nxt          = LW'(hi_clamp) + LW'(ROWS) + LW'(1);
          leaf_nxt.cost  = {1'b0, in_cost};
          leaf_nxt.need  = {1'b0, in_need};
          leaf_nxt.depth = in_depth;
          leaf_nxt.count = COUNT_W'(1);
          cur_nxt        = '0;
          hi_nxt         = '0;
          res_nxt        = '0;
          sat_nxt        = 1'b0;
          status_nxt     = STATUS_OK;
          clr_cnt_nxt    = '0;
          clr_reply_nxt  = 1'b1;
        end
      end
      S_INS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {col_r, k_r};
      end
      S_INS_TEST: begin
        // Occupied leaf: report and drop; otherwise store and fetch sibling
        if (rd_summ.count != '0) begin
          status_nxt = STATUS_OCCUPIED;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = {col_r, k_r};
          ram_wdata = leaf_r;
          cur_nxt   = leaf_r;
          ram_re    = 1'b1;
          ram_raddr = {col_r, k_r ^ NW'(1)};
        end
      end
      S_INS_UP: begin
        // Write parent, forward it, fetch the parent's sibling unless the parent is the root
        ram_we    = 1'b1;
        ram_waddr = {col_r, k_up};
        ram_wdata = join_o.res;
        cur_nxt   = join_o.res;
        sat_nxt   = sat_r | join_o.sat;
        k_nxt     = k_up;
        if (k_up == NW'(1)) begin
          status_nxt = (sat_r | join_o.sat) ? STATUS_OVERFLOW : STATUS_OK;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = {col_r, k_up ^ NW'(1)};
        end
      end
      S_Q_L: begin
        if ((l_r < h_r) && l_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = {col_r, l_r[NW-1:0]};
          l_nxt     = l_r + 1'b1;
        end
      end
      S_Q_LJ: begin
        cur_nxt = join_o.res;
        sat_nxt = sat_r | join_o.sat;
      end
      S_Q_H: begin
        if (h_r[0]) begin
          h_nxt     = h_dec;
          ram_re    = 1'b1;
          ram_raddr = {col_r, h_dec[NW-1:0]};
        end else begin
          l_nxt = l_r >> 1;
          h_nxt = h_r >> 1;
        end
      end
      S_Q_HJ: begin
        hi_nxt  = join_o.res;
        sat_nxt = sat_r | join_o.sat;
        l_nxt   = l_r >> 1;
        h_nxt   = h_r >> 1;
      end
      S_Q_FIN: begin
        res_nxt    = join_o.res;
        status_nxt = (sat_r | join_o.sat) ? STATUS_OVERFLOW : STATUS_OK;
      end
      default: begin
        col_nxt = col_r;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {res_r.count, res_r.depth, res_r.need, res_r.cost};
      out_tuser_nxt  = status_r;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      clr_reply_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_reply_r  <= clr_reply_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    k_r         <= k_nxt;
    l_r         <= l_nxt;
    h_r         <= h_nxt;
    leaf_r      <= leaf_nxt;
    cur_r       <= cur_nxt;
    hi_r        <= hi_nxt;
    res_r       <= res_nxt;
    sat_r       <= sat_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

### src/stpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/stpn_join.sv
// Shared summary join unit: first operand covers the higher rows.
// Saturating cost/need/count adds. Depends on stpn_pkg.
`default_nettype none

module stpn_join (
  input  wire stpn_pkg::summ_t     first,
  input  wire stpn_pkg::summ_t     second,
  output stpn_pkg::join_out_t      result
);

  import stpn_pkg::*;

  logic [COST_W:0]   cost_sum;
  logic [COST_W:0]   via_sum;
  logic [COUNT_W:0]  cnt_sum;
  logic [COST_W-1:0] via_sat;

  // Wide sums, carry bit flags saturation
  assign cost_sum = {1'b0, first.cost} + {1'b0, second.cost};
  assign via_sum  = {1'b0, first.cost} + {1'b0, second.need};
  assign cnt_sum  = {1'b0, first.count} + {1'b0, second.count};
  assign via_sat  = via_sum[COST_W] ? '1 : via_sum[COST_W-1:0];

  // Empty operands pass the other one through untouched
  always_comb begin
    result = '0;
    if (first.count == '0) begin
      result.res = second;
    end else if (second.count == '0) begin
      result.res = first;
    end else begin
      result.res.cost  = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
      result.res.need  = (first.need > via_sat) ? first.need : via_sat;
      result.res.depth = (first.depth > second.depth) ? first.depth : second.depth;
      result.res.count = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
      result.sat       = cost_sum[COST_W] | via_sum[COST_W] | cnt_sum[COUNT_W];
    end
  end

endmodule

`default_nettype wire

### src/stpn_chk.sv
// Port-level checker for the prefix-need block, bound to the top level.
// Depends on stpn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stpn_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [stpn_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic [stpn_pkg::OUT_USER_W-1:0]  out_tuser
);

  import stpn_pkg::*;

  // Stalled result holds its transaction
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // One transaction in flight: input closes after an accept
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // Clearing pass follows reset
  `ASSERT_IMPL(a_reset_sweep, clk, rst_n, $past(!rst_n), !in_tready)

  // Occupied-leaf reply carries no summary
  `ASSERT_IMPL(a_occupied_zero, clk, rst_n, out_tvalid && (out_tuser == STATUS_OCCUPIED), out_tdata == '0)

  // Status is one of the defined codes
  `ASSERT_IMPL(a_status_code, clk, rst_n, out_tvalid, out_tuser == STATUS_OK || out_tuser == STATUS_OCCUPIED || out_tuser == STATUS_OVERFLOW)

endmodule

bind segment_tree_prefix_need_summary stpn_chk u_stpn_chk (.*);

`default_nettype wire
